FILE: hdl/slc_pkg.sv
// ----------------------------------------------------------------------------
// slc_pkg
// Shared types and constants of the sprite line cache and pixel renderer.
// ----------------------------------------------------------------------------
package slc_pkg;

	typedef enum logic [2:0] {
		OP_SPRITE_WR = 3'd0,
		OP_CHAR_WR   = 3'd1,
		OP_PAL_WR    = 3'd2,
		OP_COLOR_WR  = 3'd3,
		OP_CACHE     = 3'd4,
		OP_RENDER    = 3'd5,
		OP_NOP6      = 3'd6,
		OP_NOP7      = 3'd7
	} op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CACHE,
		ST_RENDER,
		ST_LOOKUP,
		ST_COLOR,
		ST_DONE
	} state_t;

	localparam int REG_SCROLL_H   = 0;
	localparam int REG_SCROLL_V   = 1;
	localparam int REG_COLOR_MDL  = 2;
	localparam int REG_COMPAT     = 3;
	localparam int REG_COMPAT_BS  = 4;
	localparam int REG_NATIVE_BS  = 5;

	// sprite entry: chr 9, hoff 8, voff 8, prio 2, flags 4, pal 1, code 4
	typedef struct packed {
		logic [8:0] chr;
		logic [7:0] hoff;
		logic [7:0] voff;
		logic [1:0] prio;
		logic [3:0] flags;
		logic       pal;
		logic [3:0] code;
	} sprite_t;

	// cached tile: x 8, y 3, chr 9, prio 2, pal 1, hflip 1, code 4
	typedef struct packed {
		logic [7:0] x;
		logic [2:0] y;
		logic [8:0] chr;
		logic [1:0] prio;
		logic       pal;
		logic       hflip;
		logic [3:0] code;
	} tile_t;

	typedef struct packed {
		logic start_cache;   // clear counters and begin sprite walk
		logic cache_step;    // consume sprite read data
		logic start_render;  // clear tile index
		logic render_step;   // examine tile read data
		logic lookup_step;   // use char row data
		logic color_step;    // capture palette/color
		logic out_load;      // present result
	} cmd_t;

	typedef struct packed {
		logic walk_last;     // final sprite data is on the read port
		logic tile_none;     // no more tiles to check
		logic tile_cover;    // current tile covers the column
		logic pix_nz;        // char pixel opaque
	} sts_t;

endpackage

FILE: hdl/sprite_line_cache_and_pixel_render_top.sv
// ----------------------------------------------------------------------------
// sprite_line_cache_and_pixel_render_top
// Sprite attribute/character stores, line tile cache and pixel renderer.
// ----------------------------------------------------------------------------
// A line request walks all SPRITE_COUNT sprite entries, one per cycle through
// the sprite memory read port. A pixel request scans the cached tiles one per
// cycle through the tile memory read port while no tile covers the column; a
// covering tile with a clear pixel adds a step for the character row read and
// the opaque one a further step for the color read, and the result may then
// wait to be taken. One request is in work at a time; the result register
// frees the input side once loaded.
module sprite_line_cache_and_pixel_render_top #(
	parameter int SPRITE_COUNT = 64,
	parameter int COLOR_DEPTH  = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  operation,
	input  logic [11:0] target_index,
	input  logic [15:0] write_data,
	input  logic [7:0]  coordinate,
	input  logic [8:0]  char_number,
	input  logic [7:0]  offset_h,
	input  logic [7:0]  offset_v,
	input  logic [1:0]  sprite_priority_in,
	input  logic [3:0]  sprite_flags,
	input  logic        palette_select,
	input  logic [3:0]  color_code,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        hit,
	output logic [1:0]  pixel_priority,
	output logic [11:0] color_out
);
	import slc_pkg::*;

	logic [7:0] scroll_h_q, scroll_v_q, compat_base_q, native_base_q;
	logic       color_model_q, compat_q;
	logic [2:0] reg_idx;
	assign reg_idx = paddr[4:2];
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scroll_h_q <= '0; scroll_v_q <= '0; compat_base_q <= '0;
			native_base_q <= '0; color_model_q <= 1'b0; compat_q <= 1'b0;
		end else if (psel && penable && pwrite) begin
			case (reg_idx)
				3'(REG_SCROLL_H):  scroll_h_q <= pwdata[7:0];
				3'(REG_SCROLL_V):  scroll_v_q <= pwdata[7:0];
				3'(REG_COLOR_MDL): color_model_q <= pwdata[0];
				3'(REG_COMPAT):    compat_q <= pwdata[0];
				3'(REG_COMPAT_BS): compat_base_q <= pwdata[7:0];
				3'(REG_NATIVE_BS): native_base_q <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			3'(REG_SCROLL_H):  prdata = {24'd0, scroll_h_q};
			3'(REG_SCROLL_V):  prdata = {24'd0, scroll_v_q};
			3'(REG_COLOR_MDL): prdata = {31'd0, color_model_q};
			3'(REG_COMPAT):    prdata = {31'd0, compat_q};
			3'(REG_COMPAT_BS): prdata = {24'd0, compat_base_q};
			3'(REG_NATIVE_BS): prdata = {24'd0, native_base_q};
			default:           prdata = '0;
		endcase
	end

	cmd_t    cmd;
	sts_t    sts;
	logic    busy, acc;
	op_t     op;
	sprite_t spr_in;

	assign op       = op_t'(operation);
	assign in_ready = !busy;
	assign acc      = in_valid && in_ready;

	always_comb begin
		spr_in.chr   = char_number;
		spr_in.hoff  = offset_h;
		spr_in.voff  = offset_v;
		spr_in.prio  = sprite_priority_in;
		spr_in.flags = sprite_flags;
		spr_in.pal   = palette_select;
		spr_in.code  = color_code;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid <= 1'b0;
		else if (cmd.out_load) out_valid <= 1'b1;
		else if (out_ready) out_valid <= 1'b0;
	end

	slc_ctrl u_ctrl (
		.clk, .arst_n,
		.start_cache (acc && op == OP_CACHE),
		.start_render(acc && op == OP_RENDER),
		.sts, .out_free(!out_valid || out_ready), .cmd, .busy
	);

	logic        r_hit;
	logic [1:0]  r_prio;
	logic [11:0] r_color;

	slc_datapath #(.SPRITE_COUNT(SPRITE_COUNT), .COLOR_DEPTH(COLOR_DEPTH)) u_dp (
		.clk, .arst_n, .wr_en(acc), .op, .target_index, .write_data, .coordinate,
		.spr_in, .scroll_h(scroll_h_q), .scroll_v(scroll_v_q),
		.color_model(color_model_q), .compat_mode(compat_q),
		.compat_base(compat_base_q), .native_base(native_base_q),
		.cmd, .sts, .res_hit(r_hit), .res_prio(r_prio), .res_color(r_color)
	);

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			hit <= r_hit; pixel_priority <= r_prio; color_out <= r_color;
		end
	end

	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> !in_ready) else $error("input taken while busy");
	a_load_held: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> out_valid) else $error("result dropped");
	a_prio_hit: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !hit) |-> pixel_priority == 2'd0) else $error("prio w/o hit");
endmodule

FILE: hdl/slc_ctrl.sv
// ----------------------------------------------------------------------------
// slc_ctrl
// Sequencer for cache walk and pixel scan.
// ----------------------------------------------------------------------------
module slc_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start_cache,
	input  logic           start_render,
	input  slc_pkg::sts_t  sts,
	input  logic           out_free,
	output slc_pkg::cmd_t  cmd,
	output logic           busy
);
	import slc_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		cmd = '0;
		busy = (state_q != ST_IDLE);
		case (state_q)
			ST_IDLE: begin
				if (start_cache) begin
					cmd.start_cache = 1'b1;
					state_d = ST_CACHE;
				end else if (start_render) begin
					cmd.start_render = 1'b1;
					state_d = ST_RENDER;
				end
			end
			ST_CACHE: begin
				cmd.cache_step = 1'b1;
				if (sts.walk_last) state_d = ST_IDLE;
			end
			ST_RENDER: begin
				if (sts.tile_none) state_d = ST_DONE;
				else begin
					cmd.render_step = 1'b1;
					if (sts.tile_cover) state_d = ST_LOOKUP;
				end
			end
			ST_LOOKUP: begin
				cmd.lookup_step = 1'b1;
				state_d = sts.pix_nz ? ST_COLOR : ST_RENDER;
			end
			ST_COLOR: begin
				cmd.color_step = 1'b1;
				state_d = ST_DONE;
			end
			ST_DONE: begin
				if (out_free) begin
					cmd.out_load = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end
endmodule

FILE: hdl/slc_datapath.sv
// ----------------------------------------------------------------------------
// slc_datapath
// Stores, sprite walk, tile scan and color lookup.
// ----------------------------------------------------------------------------
module slc_datapath #(
	parameter int SPRITE_COUNT = 64,
	parameter int COLOR_DEPTH  = 256
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            wr_en,
	input  slc_pkg::op_t    op,
	input  logic [11:0]     target_index,
	input  logic [15:0]     write_data,
	input  logic [7:0]      coordinate,
	input  slc_pkg::sprite_t spr_in,
	input  logic [7:0]      scroll_h,
	input  logic [7:0]      scroll_v,
	input  logic            color_model,
	input  logic            compat_mode,
	input  logic [7:0]      compat_base,
	input  logic [7:0]      native_base,
	input  slc_pkg::cmd_t   cmd,
	output slc_pkg::sts_t   sts,
	output logic            res_hit,
	output logic [1:0]      res_prio,
	output logic [11:0]     res_color
);
	import slc_pkg::*;

	localparam int SW = (SPRITE_COUNT > 1) ? $clog2(SPRITE_COUNT) : 1;
	localparam int CW = $clog2(SPRITE_COUNT + 1);
	localparam int AW = $clog2(COLOR_DEPTH);

	sprite_t    spr_mem [SPRITE_COUNT];
	tile_t      tile_mem [SPRITE_COUNT];
	logic [15:0] char_mem [4096];
	logic [2:0] pal_mem [8];
	logic [11:0] color_mem [COLOR_DEPTH];

	logic [CW-1:0] walk_q, count_q, tidx_q;
	logic [7:0]  line_q, col_q, prev_x_q, prev_y_q;
	sprite_t     spr_rd_q;
	tile_t       tile_rd_q, tile_cur_q;
	logic [15:0] char_rd_q;
	logic [2:0]  pal_rd_q;
	logic [11:0] color_rd_q;
	logic        spr_vld_q;

	// sprite walk: the read address is issued the cycle before its data is consumed
	logic [CW-1:0] walk_rd;
	assign walk_rd = cmd.start_cache ? '0 : walk_q;

	always_ff @(posedge clk) begin
		if (wr_en && op == OP_SPRITE_WR && target_index < 12'(SPRITE_COUNT))
			spr_mem[target_index[SW-1:0]] <= spr_in;
		if (walk_rd < CW'(SPRITE_COUNT)) spr_rd_q <= spr_mem[walk_rd[SW-1:0]];
	end

	// fetch the row of the tile that becomes current at this edge
	always_ff @(posedge clk) begin
		if (wr_en && op == OP_CHAR_WR) char_mem[target_index] <= write_data;
		char_rd_q <= char_mem[cmd.render_step ? {tile_rd_q.chr, tile_rd_q.y}
			: {tile_cur_q.chr, tile_cur_q.y}];
	end

	always_ff @(posedge clk) begin
		if (wr_en && op == OP_PAL_WR) pal_mem[target_index[2:0]] <= write_data[2:0];
	end

	// opaque pixel of the current tile, from char row data
	logic [7:0] px_dx;
	logic [2:0] px_x;
	logic [1:0] pix;
	assign px_dx = tile_cur_q.x - col_q;
	assign px_x = px_dx[2:0] ^ {3{tile_cur_q.hflip}};
	assign pix  = char_rd_q[{px_x, 1'b0} +: 2];
	assign sts.pix_nz = (pix != 2'd0);

	logic [AW-1:0] cidx;
	logic [9:0]    cidx_sum;
	assign cidx_sum = compat_mode
		? {2'd0, compat_base} + {6'd0, tile_cur_q.pal, 3'd0}
			+ {7'd0, pal_mem[{tile_cur_q.pal, pix}]}
		: {2'd0, native_base} + {4'd0, tile_cur_q.code, 2'd0} + {8'd0, pix};
	assign cidx = cidx_sum[AW-1:0];

	always_ff @(posedge clk) begin
		if (wr_en && op == OP_COLOR_WR && target_index < 12'(COLOR_DEPTH))
			color_mem[target_index[AW-1:0]] <= write_data[11:0];
		if (cmd.lookup_step) begin
			color_rd_q <= color_mem[cidx];
			pal_rd_q   <= pal_mem[{tile_cur_q.pal, pix}];
		end
	end

	// resolve offsets and build the tile for the sprite on the read port
	logic [7:0] sx, sy, tx, ty;
	logic       take;
	tile_t      new_tile;
	assign sx = spr_rd_q.flags[2] ? spr_rd_q.hoff + prev_x_q : spr_rd_q.hoff;
	assign sy = spr_rd_q.flags[3] ? spr_rd_q.voff + prev_y_q : spr_rd_q.voff;
	assign tx = sx + scroll_h + 8'd7;
	assign ty = sy + scroll_v + 8'd7 - line_q;
	assign take = spr_vld_q && spr_rd_q.prio != 2'd0 && ty < 8'd8;
	always_comb begin
		new_tile.x     = tx;
		new_tile.y     = spr_rd_q.flags[1] ? ty[2:0] : ty[2:0] ^ 3'd7;
		new_tile.chr   = spr_rd_q.chr;
		new_tile.prio  = spr_rd_q.prio;
		new_tile.pal   = spr_rd_q.pal;
		new_tile.hflip = spr_rd_q.flags[0];
		new_tile.code  = spr_rd_q.code;
	end
	assign sts.walk_last = spr_vld_q && (walk_q == CW'(SPRITE_COUNT));

	always_ff @(posedge clk) begin
		if (take && count_q < CW'(SPRITE_COUNT)) tile_mem[count_q[SW-1:0]] <= new_tile;
		if (cmd.render_step && tidx_q < CW'(SPRITE_COUNT))
			tile_rd_q <= tile_mem[tidx_q[SW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			walk_q <= '0; count_q <= '0; tidx_q <= '0; spr_vld_q <= 1'b0;
			prev_x_q <= '0; prev_y_q <= '0; res_hit <= 1'b0;
			res_prio <= '0; res_color <= '0; line_q <= '0; col_q <= '0;
			tile_cur_q <= '0;
		end else begin
			if (cmd.start_cache) begin
				walk_q <= CW'(1); count_q <= '0; spr_vld_q <= 1'b1;
				prev_x_q <= '0; prev_y_q <= '0; line_q <= coordinate;
			end else if (cmd.cache_step) begin
				prev_x_q <= sx; prev_y_q <= sy;
				if (take) count_q <= count_q + CW'(1);
				if (sts.walk_last) spr_vld_q <= 1'b0;
				else walk_q <= walk_q + CW'(1);
			end
			if (cmd.start_render) begin
				tidx_q <= '0; col_q <= coordinate;
				res_hit <= 1'b0; res_prio <= '0; res_color <= '0;
			end else if (cmd.render_step) begin
				// tile_rd_q holds tile tidx_q-1 after each step, as both update at the same edge
				tidx_q <= tidx_q + CW'(1);
				tile_cur_q <= tile_rd_q;
			end
			if (cmd.color_step) begin
				res_hit   <= 1'b1;
				res_prio  <= tile_cur_q.prio;
				res_color <= !color_model ? {9'd0, pal_rd_q} : color_rd_q;
			end
		end
	end

	// tile_rd_q is read only on a scan step, so once the first step has issued
	// its read it holds tile tidx_q-1 until the next step
	logic        scan_ph_q;
	tile_t       chk;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) scan_ph_q <= 1'b0;
		else if (cmd.start_render) scan_ph_q <= 1'b0;
		else if (cmd.render_step) scan_ph_q <= 1'b1;
	end
	assign chk = tile_rd_q;
	assign sts.tile_none  = (tidx_q >= count_q) && !scan_ph_q ? 1'b1 :
		(tidx_q > count_q);
	assign sts.tile_cover = scan_ph_q && ((chk.x - col_q) < 8'd8);
endmodule
